// ----- design/fdp_pkg.sv -----
// fdp_pkg: shared types and constants for the force dot product engine
// holds payload structs, lane control struct, register and function codes
// no dependencies
`default_nettype none

package fdp_pkg;

  // default sizing of the gradient store and neighbor range
  localparam int MaxLenDefault = 256;
  localparam int MaxNbrDefault = 255;

  // configuration port widths
  localparam int CfgIndexW = 1;
  localparam int CfgDataW  = 9;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_VEC_LENGTH     = 1'b0;
  localparam logic [CfgIndexW-1:0] CFG_NEIGHBOR_COUNT = 1'b1;

  // input function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_DERIV = 1'b1;

  // input item
  typedef struct packed {
    logic               func;
    logic signed [31:0] grad_value;
    logic signed [31:0] deriv_x;
    logic signed [31:0] deriv_y;
    logic signed [31:0] deriv_z;
  } fdp_in_t;

  // result item
  typedef struct packed {
    logic signed [63:0] force_x;
    logic signed [63:0] force_y;
    logic signed [63:0] force_z;
    logic [7:0]         block_index;
    logic               last;
  } fdp_out_t;

  // control from the sequencer to each lane
  typedef struct packed {
    logic cap_en;   // capture derivative on input transfer
    logic mul_en;   // register gradient times derivative
    logic acc_en;   // accumulator takes the saturated sum
    logic acc_clr;  // accumulator back to zero
  } lane_ctrl_t;

endpackage

`default_nettype wire

// ----- design/force_dot_product_engine.sv -----
// force_dot_product_engine: top level, sequencer, config registers and lanes
// depends on fdp_pkg, fdp_grad_store, fdp_lane and fdp_merge
//
//  channel   direction  handshake            payload
//  in        input      in_valid_i/in_stall_o  fdp_pkg::fdp_in_t
//  out       output     out_valid_o/out_stall_i fdp_pkg::fdp_out_t
//  cfg       input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a gradient load is written on its transfer; a derivative triple passes through
// transfer and store read, registered product, then the saturating add;
// these steps come from the registered store read and the
// registered multiplier in front of each lane's accumulator
// a block-ending triple waits in its last cycle while the result register is
// full and stalled; reset clears counters and accumulators and sets the
// length register to 1 and the neighbor count to 0
`default_nettype none

module force_dot_product_engine #(
  parameter int MAX_LEN       = fdp_pkg::MaxLenDefault,
  parameter int MAX_NEIGHBORS = fdp_pkg::MaxNbrDefault
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire fdp_pkg::fdp_in_t                 in_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output fdp_pkg::fdp_out_t                     out_data_o,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [fdp_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  wire logic [fdp_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int AddrW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LenRaw = $clog2(MAX_LEN + 1);
  localparam int LenW   = (LenRaw > fdp_pkg::CfgDataW) ? LenRaw : fdp_pkg::CfgDataW;
  localparam int NbRaw  = $clog2(MAX_NEIGHBORS + 1);
  localparam int NbW    = (NbRaw > 8) ? NbRaw : 8;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;

  logic [1:0]                    state_q, state_d;
  logic [fdp_pkg::CfgDataW-1:0]  vec_len_q;
  logic [7:0]                    nbr_q;
  logic [AddrW-1:0]              elem_q, elem_d;
  logic [AddrW-1:0]              load_q, load_d;
  logic [NbW-1:0]                blk_q, blk_d;

  logic [LenW-1:0]   vlen_ext, eff_len, elem_next, load_next;
  logic [NbW-1:0]    nbr_ext, eff_nn;
  logic              in_xfer, load_xfer, deriv_xfer;
  logic              block_done, is_last, merge_free, advance, out_load;
  logic signed [31:0] grad_rd;
  logic signed [63:0] sum_x, sum_y, sum_z;
  fdp_pkg::lane_ctrl_t lane_ctrl;

  // input transfer decode
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign load_xfer  = in_xfer && (in_data_i.func == fdp_pkg::FUNC_LOAD);
  assign deriv_xfer = in_xfer && (in_data_i.func == fdp_pkg::FUNC_DERIV);

  // config registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_len_q <= fdp_pkg::CfgDataW'(1);
      nbr_q     <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fdp_pkg::CFG_VEC_LENGTH:     vec_len_q <= cfg_data_i;
        fdp_pkg::CFG_NEIGHBOR_COUNT: nbr_q     <= cfg_data_i[7:0];
        default:                     vec_len_q <= vec_len_q;
      endcase
    end
  end

  // effective length and neighbor count after clamping
  assign vlen_ext = LenW'(vec_len_q);
  assign eff_len  = (vec_len_q == '0) ? LenW'(1) :
                    (vlen_ext > LenW'(MAX_LEN)) ? LenW'(MAX_LEN) : vlen_ext;
  assign nbr_ext  = NbW'(nbr_q);
  assign eff_nn   = (nbr_ext > NbW'(MAX_NEIGHBORS)) ? NbW'(MAX_NEIGHBORS) : nbr_ext;

  assign elem_next  = LenW'(elem_q) + LenW'(1);
  assign load_next  = LenW'(load_q) + LenW'(1);
  assign block_done = (elem_next >= eff_len);
  assign is_last    = (blk_q >= eff_nn);

  // last cycle of a triple moves on unless a result must wait for room
  assign advance  = (state_q == ST_MUL) && (!block_done || merge_free);
  assign out_load = advance && block_done;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (deriv_xfer) state_d = ST_READ;
      ST_READ: state_d = ST_MUL;
      ST_MUL:  if (advance) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // element, block and load counters
  always_comb begin
    elem_d = elem_q;
    blk_d  = blk_q;
    load_d = load_q;
    if (load_xfer) begin
      elem_d = '0;
      blk_d  = '0;
      load_d = (load_next >= eff_len) ? '0 : load_next[AddrW-1:0];
    end else if (deriv_xfer) begin
      load_d = '0;
    end else if (advance) begin
      if (block_done) begin
        elem_d = '0;
        blk_d  = is_last ? '0 : blk_q + NbW'(1);
      end else begin
        elem_d = elem_next[AddrW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      elem_q  <= '0;
      blk_q   <= '0;
      load_q  <= '0;
    end else begin
      state_q <= state_d;
      elem_q  <= elem_d;
      blk_q   <= blk_d;
      load_q  <= load_d;
    end
  end

  // lane control shared by all three channels
  always_comb begin
    lane_ctrl.cap_en  = deriv_xfer;
    lane_ctrl.mul_en  = (state_q == ST_READ);
    lane_ctrl.acc_en  = advance && !block_done;
    lane_ctrl.acc_clr = load_xfer || out_load;
  end

  fdp_grad_store #(
    .Depth (MAX_LEN),
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (load_xfer),
    .wr_addr_i (load_q),
    .wr_data_i (in_data_i.grad_value),
    .rd_en_i   (deriv_xfer),
    .rd_addr_i (elem_q),
    .rd_data_o (grad_rd)
  );

  fdp_lane u_lane_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lane_ctrl),
    .deriv_i (in_data_i.deriv_x),
    .grad_i  (grad_rd),
    .sum_o   (sum_x)
  );

  fdp_lane u_lane_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lane_ctrl),
    .deriv_i (in_data_i.deriv_y),
    .grad_i  (grad_rd),
    .sum_o   (sum_y)
  );

  fdp_lane u_lane_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (lane_ctrl),
    .deriv_i (in_data_i.deriv_z),
    .grad_i  (grad_rd),
    .sum_o   (sum_z)
  );

  fdp_merge u_merge (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_load),
    .sum_x_i       (sum_x),
    .sum_y_i       (sum_y),
    .sum_z_i       (sum_z),
    .block_index_i (blk_q[7:0]),
    .last_i        (is_last),
    .free_o        (merge_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

  // element index never leaves the gradient store
  a_elem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LenW'(elem_q) < LenW'(MAX_LEN))
    else $error("element index beyond store depth");

  // a gradient load restarts the run counters
  a_load_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_xfer |=> (elem_q == '0) && (blk_q == '0))
    else $error("counters not cleared after gradient load");

  // a result is only written into a free result register
  a_merge_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> merge_free)
    else $error("result overwritten while held");

  // a triple passes through the read state to its accumulate step after its transfer
  a_triple_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deriv_xfer |=> ##1 (state_q == ST_MUL))
    else $error("derivative triple lost in sequencer");

endmodule

`default_nettype wire

// ----- design/fdp_grad_store.sv -----
// fdp_grad_store: gradient vector memory, one write and one registered read port
// depends on nothing outside this file
`default_nettype none

module fdp_grad_store #(
  parameter int Depth = 256,
  parameter int AddrW = 8
) (
  input  wire logic                clk_i,
  input  wire logic                wr_en_i,
  input  wire logic [AddrW-1:0]    wr_addr_i,
  input  wire logic signed [31:0]  wr_data_i,
  input  wire logic                rd_en_i,
  input  wire logic [AddrW-1:0]    rd_addr_i,
  output logic signed [31:0]       rd_data_o
);

  logic signed [31:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/fdp_lane.sv -----
// fdp_lane: one channel of the dot product, multiply then saturating accumulate
// depends on fdp_pkg for the lane control struct
`default_nettype none

module fdp_lane (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fdp_pkg::lane_ctrl_t ctrl_i,
  input  wire logic signed [31:0] deriv_i,
  input  wire logic signed [31:0] grad_i,
  output logic signed [63:0]      sum_o
);

  logic signed [31:0] deriv_q;
  logic signed [63:0] prod_q, prod_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [64:0] wide_sum;

  // derivative holding register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap_en) begin
      deriv_q <= deriv_i;
    end
  end

  // exact q32.32 product of two q16.16 values
  assign prod_d = grad_i * deriv_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // saturating add, clamp on signed overflow
  always_comb begin
    wide_sum = {acc_q[63], acc_q} + {prod_q[63], prod_q};
    if (wide_sum[64] != wide_sum[63]) begin
      sum_o = wide_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sum_o = wide_sum[63:0];
    end
  end

  // accumulator update
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc_en) begin
      acc_d = sum_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/fdp_merge.sv -----
// fdp_merge: gathers the three lane sums with block tags into the result register
// depends on fdp_pkg for the result struct
`default_nettype none

module fdp_merge (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               load_i,
  input  wire logic signed [63:0] sum_x_i,
  input  wire logic signed [63:0] sum_y_i,
  input  wire logic signed [63:0] sum_z_i,
  input  wire logic [7:0]         block_index_i,
  input  wire logic               last_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output fdp_pkg::fdp_out_t       out_data_o
);

  logic              valid_q, valid_d;
  fdp_pkg::fdp_out_t data_q;

  // slot is free when empty or when the held result leaves this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q.force_x     <= sum_x_i;
      data_q.force_y     <= sum_y_i;
      data_q.force_z     <= sum_z_i;
      data_q.block_index <= block_index_i;
      data_q.last        <= last_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

// ----- bench/force_dot_product_engine_tb.sv -----
`timescale 1ns / 1ps
// force_dot_product_engine_tb: self-checking bench for the force dot product engine
// streams gradient loads and derivative triples, predicts the saturated block sums
// depends on fdp_pkg and force_dot_product_engine
module force_dot_product_engine_tb;

  localparam int GradDepth   = 256;
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 12;
  localparam int HoldCycles  = 300;
  localparam int ReportMax   = 10;
  localparam logic [31:0] WordMax = 32'h7fff_ffff;
  localparam logic [31:0] WordMin = 32'h8000_0000;

  typedef enum int {MODE_QUIET, MODE_SENDER, MODE_RECEIVER, MODE_BOTH} idle_mode_e;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // block ports
  logic              in_valid  = 1'b0;
  logic              in_stall;
  fdp_pkg::fdp_in_t  in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  fdp_pkg::fdp_out_t out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [fdp_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [fdp_pkg::CfgDataW-1:0]  cfg_data  = '0;

  force_dot_product_engine DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // pending input items and expected block sums
  fdp_pkg::fdp_in_t  pending_items[$];
  fdp_pkg::fdp_out_t expected_forces[$];

  // predictor state, mirrors the engine after reset
  logic signed [31:0] grad_mem [GradDepth];
  logic signed [63:0] sum_x = '0, sum_y = '0, sum_z = '0;
  int unsigned elem_idx = 0, blk_cnt = 0, load_ptr = 0;
  logic [8:0] reg_len = 9'd1;
  logic [7:0] reg_nbr = 8'd0;

  // stimulus-side view of which gradient entries hold data
  bit          planned [GradDepth];
  int unsigned plan_ptr = 0;

  int items_queued = 0, items_taken = 0, loads_queued = 0;
  int results_seen = 0, mismatches = 0, cycles = 0;
  int send_idle_pct = 0, stall_pct = 0;
  int hold_trigger = 0, hold_seen = 0, hold_left = 0;

  // length register as the engine uses it
  function automatic int unsigned span_len();
    if (reg_len == 0) return 1;
    if (reg_len > GradDepth) return GradDepth;
    return reg_len;
  endfunction

  // signed 64-bit add clamped to the representable range
  function automatic logic signed [63:0] clamp_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    return s[63:0];
  endfunction

  // advance the predicted engine by one accepted item
  function automatic void step_engine(fdp_pkg::fdp_in_t item);
    int unsigned len;
    logic signed [63:0] g, px, py, pz;
    fdp_pkg::fdp_out_t res;
    len = span_len();
    if (item.func == fdp_pkg::FUNC_LOAD) begin
      grad_mem[load_ptr] = item.grad_value;
      load_ptr = (load_ptr + 1 >= len) ? 0 : load_ptr + 1;
      sum_x = '0;
      sum_y = '0;
      sum_z = '0;
      elem_idx = 0;
      blk_cnt = 0;
    end else begin
      load_ptr = 0;
      g  = $signed(grad_mem[elem_idx]);
      px = $signed(item.deriv_x);
      py = $signed(item.deriv_y);
      pz = $signed(item.deriv_z);
      sum_x = clamp_add(sum_x, g * px);
      sum_y = clamp_add(sum_y, g * py);
      sum_z = clamp_add(sum_z, g * pz);
      if (elem_idx + 1 < len) begin
        elem_idx++;
      end else begin
        res.force_x     = sum_x;
        res.force_y     = sum_y;
        res.force_z     = sum_z;
        res.block_index = blk_cnt[7:0];
        res.last        = (blk_cnt >= reg_nbr);
        expected_forces.push_back(res);
        sum_x = '0;
        sum_y = '0;
        sum_z = '0;
        elem_idx = 0;
        blk_cnt = res.last ? 0 : blk_cnt + 1;
      end
    end
  endfunction

  // input driver: hold a stalled transfer, otherwise offer the next item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        step_engine(in_data);
        items_taken++;
      end
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, counted down here
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_seen != hold_trigger) begin
      hold_left <= HoldCycles;
      hold_seen <= hold_trigger;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor: compare each transfer with the oldest expectation
  always @(posedge clk) begin : check_forces
    fdp_pkg::fdp_out_t want;
    logic bad;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_forces.size() == 0) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("result %0d with nothing expected: x=%h y=%h z=%h block=%0d last=%0b",
                     results_seen, out_data.force_x, out_data.force_y, out_data.force_z,
                     out_data.block_index, out_data.last);
        end else begin
          want = expected_forces.pop_front();
          bad = (out_data.force_x !== want.force_x) || (out_data.force_y !== want.force_y) ||
                (out_data.force_z !== want.force_z) ||
                (out_data.block_index !== want.block_index) || (out_data.last !== want.last);
          if (bad) begin
            mismatches++;
            if (mismatches <= ReportMax) begin
              $display("result %0d mismatch: expected x=%h y=%h z=%h block=%0d last=%0b",
                       results_seen, want.force_x, want.force_y, want.force_z,
                       want.block_index, want.last);
              $display("  actual x=%h y=%h z=%h block=%0d last=%0b",
                       out_data.force_x, out_data.force_y, out_data.force_z,
                       out_data.block_index, out_data.last);
            end
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("run stopped at cycle limit, %0d results outstanding", expected_forces.size());
      $display("** force_dot_product_engine: FAILED **");
      $finish;
    end
  end

  // one register write on the config channel
  task automatic write_reg(logic [fdp_pkg::CfgIndexW-1:0] idx,
                           logic [fdp_pkg::CfgDataW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == fdp_pkg::CFG_VEC_LENGTH) reg_len = val;
    else reg_nbr = val[7:0];
  endtask

  // new settings and idle pattern, written while the engine is idle
  task automatic set_phase(logic [8:0] len, logic [8:0] nbr, idle_mode_e mode);
    write_reg(fdp_pkg::CFG_VEC_LENGTH, len);
    write_reg(fdp_pkg::CFG_NEIGHBOR_COUNT, nbr);
    case (mode)
      MODE_QUIET:    begin send_idle_pct = 0;  stall_pct = 0;  end
      MODE_SENDER:   begin send_idle_pct = 78; stall_pct = 0;  end
      MODE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 78; end
      default:       begin send_idle_pct = 7;  stall_pct = 7;  end
    endcase
    @(negedge clk);
  endtask

  // wait until every item is taken and every result has arrived
  task automatic wait_drain();
    while (items_taken != items_queued || expected_forces.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly extremes and small Q16.16 values, the rest fully random
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return WordMax;
      1: return WordMin;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      4, 5: return $urandom_range(0, 32'h0004_0000) ^ {32{$urandom_range(0, 1) == 1}};
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_load(logic [31:0] word);
    fdp_pkg::fdp_in_t item;
    item.func       = fdp_pkg::FUNC_LOAD;
    item.grad_value = word;
    item.deriv_x    = $urandom();
    item.deriv_y    = $urandom();
    item.deriv_z    = $urandom();
    planned[plan_ptr] = 1'b1;
    plan_ptr = (plan_ptr + 1 >= span_len()) ? 0 : plan_ptr + 1;
    pending_items.push_back(item);
    items_queued++;
    loads_queued++;
  endtask

  task automatic queue_deriv(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
    fdp_pkg::fdp_in_t item;
    item.func       = fdp_pkg::FUNC_DERIV;
    item.grad_value = $urandom();
    item.deriv_x    = dx;
    item.deriv_y    = dy;
    item.deriv_z    = dz;
    plan_ptr = 0;
    pending_items.push_back(item);
    items_queued++;
  endtask

  // load until every entry under the current length holds data
  task automatic prime_gradient();
    int unsigned gaps;
    gaps = 0;
    for (int k = 0; k < span_len(); k++) if (!planned[k]) gaps++;
    while (gaps != 0) begin
      if (plan_ptr < span_len() && !planned[plan_ptr]) gaps--;
      queue_load(pick_word());
    end
  endtask

  task automatic fill_deriv(int n);
    repeat (n) queue_deriv(pick_word(), pick_word(), pick_word());
  endtask

  // mostly triples, with occasional partial or full gradient reloads
  task automatic fill_mix(int n);
    int k, burst;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 99) < 88) begin
        queue_deriv(pick_word(), pick_word(), pick_word());
        k++;
      end else begin
        burst = $urandom_range(1, span_len() + 1);
        repeat (burst) queue_load(pick_word());
        k += burst;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned len_pick;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // saturation both ways, clamped sums carried on, last block, restart by load
    set_phase(9'd4, 9'd1, MODE_QUIET);
    repeat (3) queue_load(WordMin);
    queue_load(WordMax);
    repeat (4) queue_deriv(WordMin, WordMax, 32'hffff_ffff);
    repeat (4) queue_deriv(WordMax, WordMin, 32'h0001_0000);
    repeat (2) queue_deriv(WordMin, WordMin, WordMax);
    queue_load(32'h0001_0000);
    queue_load(32'hffff_0000);
    repeat (4) queue_deriv(32'h0002_8000, 32'hfffe_0000, WordMin);
    wait_drain();

    // zero length acts as one, upper data bit of the neighbor count ignored
    set_phase(9'd0, 9'h100, MODE_QUIET);
    repeat (3) queue_deriv(pick_word(), pick_word(), pick_word());
    wait_drain();

    // short random blocks under each idle pattern
    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(0, 5))
        0: len_pick = 0;
        1: len_pick = 1;
        default: len_pick = $urandom_range(2, 12);
      endcase
      set_phase(len_pick[8:0], {$urandom_range(0, 1) == 1, 8'($urandom_range(0, 4))},
                idle_mode_e'(p % 4));
      prime_gradient();
      if (p == 2) begin
        // receiver holds off while the sender keeps offering
        hold_trigger++;
        fill_mix(70);
      end else if (p == 5) begin
        // sender pauses until all results are back
        fill_mix(25);
        wait_drain();
        fill_mix(25);
      end else begin
        fill_mix(45);
      end
      wait_drain();
    end

    // one-element blocks walk the block index through its whole range
    set_phase(9'd1, 9'd255, MODE_BOTH);
    prime_gradient();
    fill_deriv(270);
    wait_drain();

    // length above the store size acts as the full store
    set_phase(9'd511, 9'd0, MODE_RECEIVER);
    prime_gradient();
    fill_deriv(256);
    wait_drain();

    // full length, stopped part way into a block
    set_phase(9'd256, 9'd2, MODE_QUIET);
    fill_deriv(200);
    wait_drain();

    // shrink the length below the running element index
    set_phase(9'd3, 9'd1, MODE_SENDER);
    prime_gradient();
    fill_mix(40);
    wait_drain();

    $display("sent %0d items (%0d gradient loads), checked %0d block results, %0d mismatches",
             items_queued, loads_queued, results_seen, mismatches);
    $display("lengths 0..511, neighbor counts 0..255, saturation, reloads, stalls and hold-offs");
    if (mismatches == 0 && expected_forces.size() == 0) begin
      $display("** force_dot_product_engine: PASSED **");
    end else begin
      $display("** force_dot_product_engine: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/fdp_pkg.sv
design/fdp_grad_store.sv
design/fdp_lane.sv
design/fdp_merge.sv
design/force_dot_product_engine.sv
bench/force_dot_product_engine_tb.sv
